// File: sv/sren_pkg.sv
// Shared types and constants for the swarm rank election node.
`timescale 1ns / 1ps

package sren_pkg;

   localparam int RANK_W   = 16;
   localparam int UID_W    = 16;
   localparam int TICK_W   = 32;
   localparam int WINDOW_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_UID     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TICK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAIM_WINDOW = 2'd2;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd160;
   localparam logic [RANK_W-1:0]   UNRANKED     = 16'hFFFF;

   // LED slot/tier layout
   localparam int SLOTS_PER_TIER = 7;
   localparam int SLOT_W         = 3;
   localparam logic [RANK_W-1:0] TIER1_BASE = RANK_W'(SLOTS_PER_TIER);
   localparam logic [RANK_W-1:0] TIER2_BASE = RANK_W'(2 * SLOTS_PER_TIER);
   localparam logic [RANK_W-1:0] TIER3_BASE = RANK_W'(3 * SLOTS_PER_TIER);

   // Blink timing, period is a power of two so the phase is the low tick bits
   localparam int BLINK_PERIOD = 64;
   localparam int CYCLE_W      = $clog2(BLINK_PERIOD);
   localparam logic [CYCLE_W-1:0] TIER1_ON_END  = CYCLE_W'(16);
   localparam logic [CYCLE_W-1:0] TIER2_ON1_END = CYCLE_W'(12);
   localparam logic [CYCLE_W-1:0] TIER2_ON2_BEG = CYCLE_W'(22);
   localparam logic [CYCLE_W-1:0] TIER2_ON2_END = CYCLE_W'(34);
   localparam logic [CYCLE_W-1:0] HIGH_ON_END   = CYCLE_W'(8);

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              changed;
      logic              heard;
   } rank_upd_type;

   typedef struct packed {
      logic red;
      logic green;
      logic blue;
   } led_type;

endpackage

// File: sv/swarm_rank_election_node_core.sv
// Top level of the swarm rank election node: item pipeline, state and csr.
`timescale 1ns / 1ps
// An accepted item is held in the input register, then in the result register, where rsp offers it.
// Throughput: 1 item per cycle while rsp is not stalled; the rank update and LED decode sit in one stage.
// Backpressure on rsp stalls both stages; req_ready follows the input stage.
// Reset (synchronous, active high): rank unranked, no lower uid heard,
// node_uid 0, start_tick 0, claim window 160, both stages empty.

module swarm_rank_election_node_core (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [sren_pkg::TICK_W-1:0]     req_now_ticks,
   input  logic [sren_pkg::RANK_W-1:0]     req_nbr_rank,
   input  logic [sren_pkg::UID_W-1:0]      req_nbr_uid,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sren_pkg::RANK_W-1:0]     rsp_rank,
   output logic                            rsp_broadcast_updated,
   output logic                            rsp_led_red,
   output logic                            rsp_led_green,
   output logic                            rsp_led_blue,
   // configuration write port
   input  logic                            csr_we,
   input  logic [sren_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sren_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sren_pkg::*;

   // configuration registers
   logic [UID_W-1:0]    node_uid_ff;
   logic [TICK_W-1:0]   start_tick_ff;
   logic [WINDOW_W-1:0] claim_window_ff;

   // election state
   logic [RANK_W-1:0]   node_rank_ff;
   logic                heard_ff;

   // input stage
   logic                in_valid_ff;
   logic                in_opcode_ff;
   logic [TICK_W-1:0]   in_now_ff;
   logic [RANK_W-1:0]   in_rrank_ff;
   logic [UID_W-1:0]    in_ruid_ff;

   // result stage
   logic                out_valid_ff;
   logic [RANK_W-1:0]   out_rank_ff;
   logic                out_changed_ff;
   led_type             out_led_ff;

   logic                out_free;
   logic                advance;
   rank_upd_type        upd;
   led_type             led_in;

   // result register frees when empty or being taken; input stage moves on then
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_uid_ff     <= '0;
         start_tick_ff   <= '0;
         claim_window_ff <= WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_UID:     node_uid_ff     <= csr_wdata[UID_W-1:0];
            CSR_START_TICK:   start_tick_ff   <= csr_wdata[TICK_W-1:0];
            CSR_CLAIM_WINDOW: claim_window_ff <= csr_wdata[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_opcode_ff <= req_opcode;
         in_now_ff    <= req_now_ticks;
         in_rrank_ff  <= req_nbr_rank;
         in_ruid_ff   <= req_nbr_uid;
      end
   end

   sren_update u_update (
      .opcode       (in_opcode_ff),
      .now_ticks    (in_now_ff),
      .nbr_rank     (in_rrank_ff),
      .nbr_uid      (in_ruid_ff),
      .node_uid     (node_uid_ff),
      .start_tick   (start_tick_ff),
      .claim_window (claim_window_ff),
      .cur_rank     (node_rank_ff),
      .cur_heard    (heard_ff),
      .upd          (upd)
   );

   sren_led u_led (
      .rank  (upd.rank),
      .cycle (in_now_ff[CYCLE_W-1:0]),
      .led   (led_in)
   );

   // state commits as the item moves into the result register, so the
   // next item in the input stage sees it on the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         node_rank_ff <= UNRANKED;
         heard_ff     <= 1'b0;
      end else if (advance) begin
         node_rank_ff <= upd.rank;
         heard_ff     <= upd.heard;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rank_ff    <= upd.rank;
         out_changed_ff <= upd.changed;
         out_led_ff     <= led_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_rank              = out_rank_ff;
   assign rsp_broadcast_updated = out_changed_ff;
   assign rsp_led_red           = out_led_ff.red;
   assign rsp_led_green         = out_led_ff.green;
   assign rsp_led_blue          = out_led_ff.blue;

`ifndef SYNTHESIS
   // rank only ever moves down
   a_rank_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> node_rank_ff <= $past(node_rank_ff))
      else $error("node rank increased");

   // lower-uid flag is sticky
   a_heard_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(heard_ff))
      else $error("lower uid flag cleared");

   // a rank change always lands on an assigned rank
   a_change_ranked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_broadcast_updated |-> rsp_rank != UNRANKED)
      else $error("broadcast update with unranked rank");

   // unranked shows blue only
   a_unranked_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rank == UNRANKED) |->
         rsp_led_blue && !rsp_led_red && !rsp_led_green)
      else $error("unranked node not blue");

   // a stalled input stage keeps its item
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_rrank_ff))
      else $error("input stage lost an item");
`endif

endmodule

// File: sv/sren_update.sv
// Rank gradient, lower-uid tracking and rank-zero claim for one item.
`timescale 1ns / 1ps

module sren_update (
   input  logic                          opcode,
   input  logic [sren_pkg::TICK_W-1:0]   now_ticks,
   input  logic [sren_pkg::RANK_W-1:0]   nbr_rank,
   input  logic [sren_pkg::UID_W-1:0]    nbr_uid,
   input  logic [sren_pkg::UID_W-1:0]    node_uid,
   input  logic [sren_pkg::TICK_W-1:0]   start_tick,
   input  logic [sren_pkg::WINDOW_W-1:0] claim_window,
   input  logic [sren_pkg::RANK_W-1:0]   cur_rank,
   input  logic                          cur_heard,
   output sren_pkg::rank_upd_type        upd
);
   import sren_pkg::*;

   logic [RANK_W-1:0] cand;
   logic              take_cand;
   logic [RANK_W-1:0] grad_rank;
   logic              heard;
   logic [TICK_W-1:0] elapsed;
   logic              window_over;
   logic              claim;

   always_comb begin
      cand      = nbr_rank + RANK_W'(1);
      take_cand = opcode && (nbr_rank != UNRANKED) && (cand < cur_rank);
      grad_rank = take_cand ? cand : cur_rank;
      heard     = cur_heard || (opcode && (nbr_uid < node_uid));
      // modulo-2^32 elapsed, so counter wrap behaves
      elapsed     = now_ticks - start_tick;
      window_over = (elapsed[TICK_W-1:WINDOW_W] != '0) ||
                    (elapsed[WINDOW_W-1:0] > claim_window);
      claim       = (grad_rank == UNRANKED) && window_over && !heard;

      upd.rank    = claim ? '0 : grad_rank;
      upd.changed = take_cand || claim;
      upd.heard   = heard;
   end

endmodule

// File: sv/sren_led.sv
// LED colour decode from rank and tick phase.
`timescale 1ns / 1ps

module sren_led (
   input  logic [sren_pkg::RANK_W-1:0]  rank,
   input  logic [sren_pkg::CYCLE_W-1:0] cycle,
   output sren_pkg::led_type            led
);
   import sren_pkg::*;

   logic [RANK_W-1:0] slot_full;
   logic [SLOT_W-1:0] slot;
   logic              on;

   // Tier found by compares; only tiers 0..2 need the slot
   always_comb begin
      led       = '0;
      on        = 1'b0;
      slot_full = rank;
      if (rank == UNRANKED) begin
         led.blue = 1'b1;
      end else if (rank >= TIER3_BASE) begin
         on        = cycle < HIGH_ON_END;
         led.red   = on;
         led.green = on;
         led.blue  = on;
      end else begin
         if (rank < TIER1_BASE) begin
            on = 1'b1;
         end else if (rank < TIER2_BASE) begin
            slot_full = rank - TIER1_BASE;
            on        = cycle < TIER1_ON_END;
         end else begin
            slot_full = rank - TIER2_BASE;
            on        = (cycle < TIER2_ON1_END) ||
                        ((cycle >= TIER2_ON2_BEG) && (cycle < TIER2_ON2_END));
         end
         led.red   = on && slot[0];
         led.green = on && slot[1];
         led.blue  = on && slot[2];
      end
   end

   assign slot = slot_full[SLOT_W-1:0];

endmodule

// File: test/swarm_rank_election_node_core_tb.sv
// Self-checking testbench for the swarm rank election node core.
`timescale 1ns / 1ps

module swarm_rank_election_node_core_tb;
   import sren_pkg::*;

   // Loop pass kinds on req_opcode
   typedef enum logic {
      OP_NO_MSG   = 1'b0,
      OP_WITH_MSG = 1'b1
   } pass_op_type;

   // Register index with no register behind it; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int RANDOM_PHASES    = 8;
   localparam int PASSES_PER_PHASE = 100;
   localparam int DRAIN_PAUSE      = 4;    // pause after the last report, as margin
   localparam int QUIET_LIMIT      = 2000; // cycles without any handshake

   typedef struct {
      pass_op_type       op;
      logic [TICK_W-1:0] now;
      logic [RANK_W-1:0] rank;
      logic [UID_W-1:0]  uid;
   } loop_pass_type;

   typedef struct {
      logic [RANK_W-1:0] rank;
      logic              updated;
      led_type           led;
   } rank_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_opcode    = 1'b0;
   logic [TICK_W-1:0]     req_now_ticks = '0;
   logic [RANK_W-1:0]     req_nbr_rank  = '0;
   logic [UID_W-1:0]      req_nbr_uid   = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RANK_W-1:0]     rsp_rank;
   logic                  rsp_broadcast_updated;
   logic                  rsp_led_red;
   logic                  rsp_led_green;
   logic                  rsp_led_blue;

   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   swarm_rank_election_node_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_now_ticks         (req_now_ticks),
      .req_nbr_rank          (req_nbr_rank),
      .req_nbr_uid           (req_nbr_uid),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_rank              (rsp_rank),
      .rsp_broadcast_updated (rsp_broadcast_updated),
      .rsp_led_red           (rsp_led_red),
      .rsp_led_green         (rsp_led_green),
      .rsp_led_blue          (rsp_led_blue),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the node: configuration copy and election state
   logic [UID_W-1:0]    cfg_uid    = '0;
   logic [TICK_W-1:0]   cfg_start  = '0;
   logic [WINDOW_W-1:0] cfg_window = WINDOW_RESET;
   logic [RANK_W-1:0]   shadow_rank  = UNRANKED;
   logic                shadow_heard = 1'b0;

   loop_pass_type   pending_passes[$];   // filled by the stimulus, drained by the driver
   rank_report_type expected_reports[$]; // one per accepted pass, oldest first
   loop_pass_type   held_pass;           // item currently on the req port

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatches     = 0;
   int unsigned reports_checked = 0;
   int unsigned rank_changes   = 0;
   int unsigned tier_seen[4]   = '{0, 0, 0, 0};
   int unsigned quiet_cycles   = 0;

   // Tick phases right at the blink window edges
   int unsigned blink_marks[12] = '{0, 7, 8, 11, 12, 15, 16, 21, 22, 33, 34, 63};

   // Advance the shadow state by one loop pass and return the report it owes.
   // Gradient first, then the rank-zero claim, so a pass that lowers the rank
   // can never also claim.
   function automatic rank_report_type elect_rank(loop_pass_type p);
      rank_report_type r;
      logic [RANK_W-1:0] hop;
      logic [TICK_W-1:0] elapsed;
      int unsigned tier, slot, blink;
      logic lit;
      r.updated = 1'b0;
      if (p.op == OP_WITH_MSG) begin
         if (p.uid < cfg_uid) shadow_heard = 1'b1;
         if (p.rank != UNRANKED) begin
            hop = p.rank + 16'd1;
            if (hop < shadow_rank) begin
               shadow_rank = hop;
               r.updated   = 1'b1;
            end
         end
      end
      // modulo-2^32 difference, so a tick wrap looks like a plain count
      elapsed = p.now - cfg_start;
      if (shadow_rank == UNRANKED && elapsed > TICK_W'(cfg_window) && !shadow_heard) begin
         shadow_rank = '0;
         r.updated   = 1'b1;
      end
      r.rank = shadow_rank;
      if (r.updated) rank_changes++;
      if (shadow_rank == UNRANKED) begin
         r.led = '{red: 1'b0, green: 1'b0, blue: 1'b1};
      end else begin
         // full-width divide; the tier is not cut to 8 bits
         tier  = shadow_rank / SLOTS_PER_TIER;
         slot  = shadow_rank % SLOTS_PER_TIER;
         blink = p.now % BLINK_PERIOD;
         tier_seen[(tier > 3) ? 3 : tier]++;
         if (tier >= 3) begin
            lit   = (blink < 8);
            r.led = '{red: lit, green: lit, blue: lit};
         end else begin
            case (tier)
               0: lit = 1'b1;
               1: lit = (blink < 16);
               default: lit = (blink < 12) || (blink >= 22 && blink < 34);
            endcase
            r.led = '{red: lit & slot[0], green: lit & slot[1], blue: lit & slot[2]};
         end
      end
      return r;
   endfunction

   // Random pass whose message rank mostly walks a ladder from top down to
   // bottom over the phase, so the node's rank keeps dropping step by step.
   function automatic loop_pass_type random_pass(int unsigned top, int unsigned bottom,
                                                 int unsigned k, int unsigned n);
      loop_pass_type p;
      int unsigned ladder, stepped, pick;
      ladder = top - ((top - bottom) * k) / n;
      p.op   = ($urandom_range(99) < 75) ? OP_WITH_MSG : OP_NO_MSG;
      pick   = $urandom_range(99);
      if (pick < 55) begin
         stepped = ladder + $urandom_range(2);
         p.rank  = RANK_W'((stepped > 65535) ? 65535 : stepped);
      end else if (pick < 80) begin
         p.rank = RANK_W'($urandom_range(65535, bottom));
      end else if (pick < 92) begin
         p.rank = UNRANKED;
      end else begin
         p.rank = 16'hFFFE;
      end
      p.uid = ($urandom_range(99) < 15) ? cfg_uid : UID_W'($urandom_range(65535));
      if ($urandom_range(1) != 0) p.now = $urandom();
      else p.now = ($urandom() & 32'hFFFF_FFC0) | blink_marks[$urandom_range(11)];
      return p;
   endfunction

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_pass(pass_op_type op, logic [TICK_W-1:0] now,
                             logic [RANK_W-1:0] rank, logic [UID_W-1:0] uid);
      loop_pass_type p;
      p = '{op: op, now: now, rank: rank, uid: uid};
      pending_passes.push_back(p);
   endtask

   // Register write; the shadow copy follows the same width masking
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_NODE_UID:     cfg_uid    = data[UID_W-1:0];
         CSR_START_TICK:   cfg_start  = data[TICK_W-1:0];
         CSR_CLAIM_WINDOW: cfg_window = data[WINDOW_W-1:0];
         default: ;
      endcase
   endtask

   // Wait until every queued item went in and every report came back;
   // sampled mid-cycle so the edge updates have all landed
   task automatic settle();
      while (pending_passes.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Driver: holds an item until it is taken, then maybe gaps before the next.
   // The report for an item is predicted at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_reports.push_back(elect_rank(held_pass));
         if (!req_valid || req_ready) begin
            if (pending_passes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               held_pass = pending_passes.pop_front();
               req_valid     <= 1'b1;
               req_opcode    <= held_pass.op;
               req_now_ticks <= held_pass.now;
               req_nbr_rank  <= held_pass.rank;
               req_nbr_uid   <= held_pass.uid;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random backpressure, each taken report against the oldest prediction
   always @(posedge clock) begin
      rank_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("report with no pass outstanding: rank %0d", rsp_rank);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("rank", want.rank, rsp_rank);
               compare_field("broadcast_updated", want.updated, rsp_broadcast_updated);
               compare_field("led_red", want.led.red, rsp_led_red);
               compare_field("led_green", want.led.green, rsp_led_green);
               compare_field("led_blue", want.led.blue, rsp_led_blue);
               reports_checked++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: a long stretch with no handshake on either side means a hang
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Stimulus. The rank only ever falls and reset comes once, so the run is
   // one long descent: unranked corner cases first, then message ranks that
   // step down through the high tiers, tier 2, tier 1 and finally tier 0.
   initial begin
      int unsigned ladder_top[RANDOM_PHASES]    = '{65534, 30000, 1000, 60, 20, 13, 6, 0};
      int unsigned ladder_bottom[RANDOM_PHASES] = '{30000, 1000,  60,  21, 13, 6,  0, 0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Upper bits of the 16-bit registers are junk and must be dropped.
      // Start sits just below the tick wrap so the window straddles it.
      write_csr(CSR_NODE_UID, 32'hA5A5_8000);
      write_csr(CSR_START_TICK, 32'hFFFF_FFF0);
      write_csr(CSR_CLAIM_WINDOW, 32'h5A5A_0020);
      write_csr(CSR_SPARE, 32'hFFFF_FFFF);

      // unranked: no time elapsed
      queue_pass(OP_NO_MSG,   32'hFFFF_FFF0, UNRANKED, 16'h0000);
      // elapsed equals the window across the wrap: no claim; unranked sender ignored
      queue_pass(OP_WITH_MSG, 32'h0000_0010, UNRANKED, 16'hFFFF);
      // neighbour one below unranked: plus one gives unranked, no change
      queue_pass(OP_WITH_MSG, 32'h0000_0010, 16'hFFFE, 16'h8000);
      queue_pass(OP_NO_MSG,   32'h0000_0000, 16'hFFFF, 16'hFFFF);
      // window passed and a rank arrives in the same pass: gradient wins, no claim
      queue_pass(OP_WITH_MSG, 32'h0000_0011, 16'hFFFD, 16'hFFFF);
      // lower uid heard, same rank again: no change
      queue_pass(OP_WITH_MSG, 32'h0000_0011, 16'hFFFD, 16'h7FFF);
      // high tier, white blink edges
      queue_pass(OP_WITH_MSG, 32'h0000_0007, 16'h8000, 16'h0000);
      queue_pass(OP_NO_MSG,   32'h0000_0008, 16'h0000, 16'h0000);
      queue_pass(OP_NO_MSG,   32'h0000_003F, 16'h0000, 16'h0000);
      queue_pass(OP_NO_MSG,   32'h0000_0040, 16'h0000, 16'h0000);
      queue_pass(OP_NO_MSG,   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      queue_pass(OP_WITH_MSG, 32'h0000_0000, 16'h8000, 16'hFFFF);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // register settings: all-low, all-high, then random
         if (ph == 0) begin
            write_csr(CSR_NODE_UID, {16'($urandom()), 16'h0000});
            write_csr(CSR_START_TICK, 32'h0000_0000);
            write_csr(CSR_CLAIM_WINDOW, {16'($urandom()), 16'h0000});
         end else if (ph == 1) begin
            write_csr(CSR_NODE_UID, {16'($urandom()), 16'hFFFF});
            write_csr(CSR_START_TICK, 32'hFFFF_FFFF);
            write_csr(CSR_CLAIM_WINDOW, {16'($urandom()), 16'hFFFF});
         end else begin
            write_csr(CSR_NODE_UID, $urandom());
            write_csr(CSR_START_TICK, $urandom());
            write_csr(CSR_CLAIM_WINDOW, $urandom());
         end
         write_csr(CSR_SPARE, $urandom());

         // idling: none, sender gaps, receiver stalls, both
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase

         for (int k = 0; k < PASSES_PER_PHASE; k++)
            pending_passes.push_back(random_pass(ladder_top[ph], ladder_bottom[ph], k,
                                                 PASSES_PER_PHASE));
         settle();
      end

      $display("checked %0d reports over %0d register settings, %0d rank changes, final rank %0d",
               reports_checked, RANDOM_PHASES + 1, rank_changes, shadow_rank);
      $display("reports per tier 0/1/2/3+: %0d/%0d/%0d/%0d",
               tier_seen[0], tier_seen[1], tier_seen[2], tier_seen[3]);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
